FILE: hw/rtl/i2cseq_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
// Used by the front end, back end, top and checker; depends on nothing.
package i2cseq_pkg;

   localparam int MAX_BYTES_DEFAULT = 256;
   localparam int QUEUE_DEPTH       = 4;

   localparam int RATE_W          = 10;
   localparam int RATE_RESET_KHZ  = 100;
   localparam int RATE_SLOW_KHZ   = 50;
   localparam int RATE_MID_KHZ    = 100;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic CSR_IDX_RATE_KHZ = 1'b0;

   localparam logic [1:0] DIV_100K = 2'd0;
   localparam logic [1:0] DIV_50K  = 2'd1;
   localparam logic [1:0] DIV_25K  = 2'd2;

   localparam logic [1:0] MODE_UNSPEC = 2'd0;
   localparam logic [1:0] BUS_MAX     = 2'd1;

   localparam int EVF_DATA = 0;
   localparam int EVF_ADDR = 1;
   localparam int EVF_STOP = 2;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_START   = 2'd1,
      ACT_EVENT   = 2'd2,
      ACT_TIMEOUT = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_ADDR  = 3'd1,
      CMD_ACK   = 3'd2,
      CMD_NOACK = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NORESP  = 3'd1,
      ST_ABORT   = 3'd2,
      ST_TIMEOUT = 3'd3,
      ST_BADMODE = 3'd4,
      ST_BADBUS  = 3'd5
   } status_type;

   typedef struct packed {
      action_type  action;
      logic        is_read;
      logic [1:0]  transfer_mode;
      logic [1:0]  bus_select;
      logic [6:0]  device_address;
      logic [7:0]  sub_address;
      logic [8:0]  byte_count;
      logic [7:0]  buffer_index;
      logic [7:0]  data_byte;
      logic [2:0]  event_flags;
      logic        last_acked;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  mode_value;
      logic [7:0]  address_value;
      logic [7:0]  subaddress_value;
      cmd_type     command;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_valid;
      logic [7:0]  rx_byte;
      logic        done_res;
      status_type  status;
      logic [8:0]  bytes_done;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      logic            tx_read;
      rsp_payload_type res;
   } front_res_type;

   typedef struct packed {
      logic full;
   } back_status_type;

endpackage

FILE: hw/rtl/i2cseq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module i2cseq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/i2cseq_front.sv
// Front end: accepts transactions, holds the rate register and sequencing state,
// decides each result and drives the write store. Depends on i2cseq_pkg.
module i2cseq_front #(
   parameter int MAX_BYTES = i2cseq_pkg::MAX_BYTES_DEFAULT,
   localparam int AW = $clog2(MAX_BYTES > 1 ? MAX_BYTES : 2)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  i2cseq_pkg::req_payload_type       req_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [i2cseq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2cseq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2cseq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready,
   input  i2cseq_pkg::back_status_type       back_status,
   output i2cseq_pkg::front_res_type         front_res,
   output logic                              ram_we,
   output logic [AW-1:0]                     ram_waddr,
   output logic [7:0]                        ram_wdata,
   output logic [AW-1:0]                     ram_raddr
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   logic [i2cseq_pkg::RATE_W-1:0] rate_khz_ff;
   logic                          in_progress_ff, in_progress_in;
   logic                          read_direction_ff, read_direction_in;
   logic [CNT_W-1:0]              total_count_ff, total_count_in;
   logic [CNT_W-1:0]              next_index_ff, next_index_in;
   i2cseq_pkg::status_type        result_code_ff, result_code_in;
   logic                          stop_seen_ff, stop_seen_in;

   logic                          accept;
   logic                          csr_write;
   logic [1:0]                    divider;
   logic [CNT_W-1:0]              count_sat;
   logic [CNT_W-1:0]              tx_index;
   i2cseq_pkg::front_res_type     res;

   assign req_stall  = back_status.full;
   assign accept     = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == i2cseq_pkg::CSR_IDX_RATE_KHZ)
                       ? i2cseq_pkg::CSR_DATA_W'(rate_khz_ff) : '0;

   always_comb begin
      if (32'(rate_khz_ff) < 32'(i2cseq_pkg::RATE_SLOW_KHZ)) begin
         divider = i2cseq_pkg::DIV_25K;
      end else if (32'(rate_khz_ff) < 32'(i2cseq_pkg::RATE_MID_KHZ)) begin
         divider = i2cseq_pkg::DIV_50K;
      end else begin
         divider = i2cseq_pkg::DIV_100K;
      end
      if (32'(req_payload.byte_count) > 32'(MAX_BYTES)) begin
         count_sat = CNT_W'(MAX_BYTES);
      end else begin
         count_sat = CNT_W'(req_payload.byte_count);
      end
   end

   always_comb begin
      in_progress_in    = in_progress_ff;
      read_direction_in = read_direction_ff;
      total_count_in    = total_count_ff;
      next_index_in     = next_index_ff;
      result_code_in    = result_code_ff;
      stop_seen_in      = stop_seen_ff;
      tx_index          = next_index_ff;
      res               = '0;
      res.res.command   = i2cseq_pkg::CMD_NONE;
      res.res.status    = i2cseq_pkg::ST_OK;

      case (req_payload.action)
         i2cseq_pkg::ACT_LOAD: begin
         end
         i2cseq_pkg::ACT_START: begin
            in_progress_in = 1'b0;
            res.valid      = 1'b1;
            if (req_payload.transfer_mode == i2cseq_pkg::MODE_UNSPEC) begin
               res.res.done_res = 1'b1;
               res.res.status   = i2cseq_pkg::ST_BADMODE;
            end else if (req_payload.bus_select > i2cseq_pkg::BUS_MAX) begin
               res.res.done_res = 1'b1;
               res.res.status   = i2cseq_pkg::ST_BADBUS;
            end else begin
               in_progress_in    = 1'b1;
               read_direction_in = req_payload.is_read;
               total_count_in    = count_sat;
               next_index_in     = '0;
               result_code_in    = i2cseq_pkg::ST_OK;
               stop_seen_in      = 1'b0;
               res.res.mode_value = {req_payload.bus_select[0],
                                     req_payload.transfer_mode, divider};
               res.res.address_value    = {req_payload.device_address,
                                           req_payload.is_read};
               res.res.subaddress_value = req_payload.sub_address;
               res.res.command          = i2cseq_pkg::CMD_ADDR;
            end
         end
         i2cseq_pkg::ACT_TIMEOUT: begin
            if (in_progress_ff) begin
               res.valid        = 1'b1;
               in_progress_in   = 1'b0;
               res.res.done_res = 1'b1;
               res.res.bytes_done = 9'(next_index_ff);
               if (result_code_ff == i2cseq_pkg::ST_OK && !stop_seen_ff) begin
                  res.res.status = i2cseq_pkg::ST_TIMEOUT;
               end else begin
                  res.res.status = result_code_ff;
               end
            end
         end
         i2cseq_pkg::ACT_EVENT: begin
            if (in_progress_ff) begin
               res.valid = 1'b1;
               if (read_direction_ff) begin
                  if (req_payload.event_flags[i2cseq_pkg::EVF_ADDR]) begin
                     if (req_payload.last_acked) begin
                        res.res.command = (total_count_ff > CNT_W'(1))
                                          ? i2cseq_pkg::CMD_ACK : i2cseq_pkg::CMD_NOACK;
                     end else begin
                        result_code_in = i2cseq_pkg::ST_NORESP;
                     end
                  end
                  if (req_payload.event_flags[i2cseq_pkg::EVF_DATA]) begin
                     if (next_index_in < total_count_ff) begin
                        res.res.rx_valid = 1'b1;
                        res.res.rx_byte  = req_payload.data_byte;
                        next_index_in    = next_index_in + CNT_W'(1);
                     end
                     if (next_index_in < total_count_ff) begin
                        res.res.command = ((CNT_W+1)'(next_index_in) + (CNT_W+1)'(1)
                                           >= (CNT_W+1)'(total_count_ff))
                                          ? i2cseq_pkg::CMD_NOACK : i2cseq_pkg::CMD_ACK;
                     end
                  end
               end else begin
                  if (req_payload.event_flags[i2cseq_pkg::EVF_ADDR]) begin
                     if (req_payload.last_acked) begin
                        if (next_index_in < total_count_ff) begin
                           res.tx_read      = 1'b1;
                           res.res.tx_valid = 1'b1;
                           tx_index         = next_index_in;
                           next_index_in    = next_index_in + CNT_W'(1);
                        end else begin
                           res.res.command = i2cseq_pkg::CMD_STOP;
                        end
                     end else begin
                        result_code_in = i2cseq_pkg::ST_NORESP;
                     end
                  end
                  if (req_payload.event_flags[i2cseq_pkg::EVF_DATA]) begin
                     if (req_payload.last_acked) begin
                        if (next_index_in < total_count_ff) begin
                           res.tx_read      = 1'b1;
                           res.res.tx_valid = 1'b1;
                           tx_index         = next_index_in;
                           next_index_in    = next_index_in + CNT_W'(1);
                        end else begin
                           res.res.command = i2cseq_pkg::CMD_STOP;
                        end
                     end else begin
                        result_code_in = i2cseq_pkg::ST_ABORT;
                     end
                  end
               end
               if (req_payload.event_flags[i2cseq_pkg::EVF_STOP]) begin
                  stop_seen_in     = 1'b1;
                  in_progress_in   = 1'b0;
                  res.res.done_res = 1'b1;
               end
               res.res.status     = result_code_in;
               res.res.bytes_done = 9'(next_index_in);
            end
         end
         default: begin
         end
      endcase
   end

   assign front_res.valid   = accept && res.valid;
   assign front_res.tx_read = res.tx_read;
   assign front_res.res     = res.res;

   assign ram_we    = accept && (req_payload.action == i2cseq_pkg::ACT_LOAD)
                      && (32'(req_payload.buffer_index) < 32'(MAX_BYTES));
   assign ram_waddr = AW'(req_payload.buffer_index);
   assign ram_wdata = req_payload.data_byte;
   assign ram_raddr = AW'(tx_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_khz_ff       <= i2cseq_pkg::RATE_W'(i2cseq_pkg::RATE_RESET_KHZ);
         in_progress_ff    <= 1'b0;
         read_direction_ff <= 1'b0;
         total_count_ff    <= '0;
         next_index_ff     <= '0;
         result_code_ff    <= i2cseq_pkg::ST_OK;
         stop_seen_ff      <= 1'b0;
      end else begin
         if (csr_write && csr_paddr[2] == i2cseq_pkg::CSR_IDX_RATE_KHZ) begin
            rate_khz_ff <= csr_pwdata[i2cseq_pkg::RATE_W-1:0];
         end
         if (accept) begin
            in_progress_ff    <= in_progress_in;
            read_direction_ff <= read_direction_in;
            total_count_ff    <= total_count_in;
            next_index_ff     <= next_index_in;
            result_code_ff    <= result_code_in;
            stop_seen_ff      <= stop_seen_in;
         end
      end
   end

endmodule

FILE: hw/rtl/i2cseq_back.sv
// Back end: stages front results, merges the write-store byte and queues
// transactions for the result channel. Depends on i2cseq_pkg.
module i2cseq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  i2cseq_pkg::front_res_type     front_res,
   input  logic [7:0]                    ram_rdata,
   output i2cseq_pkg::back_status_type   back_status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output i2cseq_pkg::rsp_payload_type   rsp_payload
);

   localparam int PTR_W = $clog2(i2cseq_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(i2cseq_pkg::QUEUE_DEPTH + 1);

   logic                          pipe_valid_ff;
   logic                          pipe_txrd_ff;
   i2cseq_pkg::rsp_payload_type   pipe_res_ff;
   i2cseq_pkg::rsp_payload_type   queue_ff [i2cseq_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]              wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   i2cseq_pkg::rsp_payload_type   push_res;
   logic                          push, pop;

   always_comb begin
      push_res         = pipe_res_ff;
      push_res.tx_byte = pipe_txrd_ff ? ram_rdata : 8'd0;
   end

   assign push      = pipe_valid_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   assign count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   assign back_status.full = ((CNT_W+1)'(count_ff) + (CNT_W+1)'(pipe_valid_ff))
                             >= (CNT_W+1)'(i2cseq_pkg::QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      pipe_res_ff  <= front_res.res;
      pipe_txrd_ff <= front_res.tx_read;
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         pipe_valid_ff <= front_res.valid;
         count_ff      <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

FILE: hw/rtl/i2c_master_transaction_sequencer_top.sv
// Path: an accepted transaction's result is registered in the back-end pipe stage,
// then written to the result queue, from which rsp offers it.
// Throughput: one transaction per cycle while req_stall is low, set by the single
// write-store read port; the four-entry result queue lets req proceed while rsp stalls.
// Reset: synchronous; clears sequencing state and the queue, rate_khz returns to 100.
// The write store is not cleared; entries hold nothing defined until loaded.
module i2c_master_transaction_sequencer_top #(
   parameter int MAX_BYTES = i2cseq_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  i2cseq_pkg::req_payload_type       req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output i2cseq_pkg::rsp_payload_type       rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [i2cseq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2cseq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2cseq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int AW = $clog2(MAX_BYTES > 1 ? MAX_BYTES : 2);

   i2cseq_pkg::front_res_type   front_res;
   i2cseq_pkg::back_status_type back_status;
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [7:0]                  ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [7:0]                  ram_rdata;

   i2cseq_front #(.MAX_BYTES(MAX_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .back_status (back_status),
      .front_res   (front_res),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr)
   );

   i2cseq_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   i2cseq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .front_res   (front_res),
      .ram_rdata   (ram_rdata),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hw/rtl/i2cseq_checker.sv
// Port-level checks for the sequencer top, attached by bind.
// Depends on i2cseq_pkg and i2c_master_transaction_sequencer_top.
module i2cseq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input i2cseq_pkg::rsp_payload_type rsp_payload
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled transaction changed or dropped");

   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.tx_valid |-> rsp_payload.tx_byte == 8'd0)
      else $error("tx_byte nonzero without tx_valid");

   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.rx_valid |-> rsp_payload.rx_byte == 8'd0)
      else $error("rx_byte nonzero without rx_valid");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.command == i2cseq_pkg::CMD_ADDR
      |-> !rsp_payload.done_res && rsp_payload.status == i2cseq_pkg::ST_OK
          && rsp_payload.bytes_done == 9'd0)
      else $error("address command on a finished or failed transaction");

endmodule

bind i2c_master_transaction_sequencer_top i2cseq_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
